// ===== rtl/core/gbl_pkg.sv =====
// ----------------------------------------------------------------------------
// gbl_pkg
// shared types, constants and register codes of the 3x3 gaussian blur stream
// ----------------------------------------------------------------------------
`default_nettype none

package gbl_pkg;

    localparam int PIX_W          = 8;
    localparam int OUT_COORD_W    = 10;
    localparam int SIZE_W         = 11;
    localparam int COEF_W         = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int SIDE_SUM_W     = PIX_W + 2;
    localparam int FRAC_W         = 16;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = 11'd1024;
    localparam logic [COEF_W-1:0] RST_COEF_CENTER  = 16'd13381;
    localparam logic [COEF_W-1:0] RST_COEF_SIDE    = 16'd8116;
    localparam logic [COEF_W-1:0] RST_COEF_CORNER  = 16'd4922;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_COEF_CENTER  = 3'd2,
        REG_COEF_SIDE    = 3'd3,
        REG_COEF_CORNER  = 3'd4
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pix_t;

    // entry k*3+j: row k (0 oldest line, 2 current line), column j (2 newest)
    typedef logic [8:0][PIX_W-1:0] window_t;

    typedef struct packed {
        logic has_up;
        logic last_row;
        logic has_left;
        logic last_col;
    } item_flags_t;

    typedef struct packed {
        logic [COEF_W-1:0] center;
        logic [COEF_W-1:0] side;
        logic [COEF_W-1:0] corner;
    } coefs_t;

endpackage

`default_nettype wire

// ===== rtl/core/gbl_ram.sv =====
// ----------------------------------------------------------------------------
// gbl_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module gbl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/gbl_front.sv =====
// ----------------------------------------------------------------------------
// gbl_front
// accepts pixels, tracks position, runs the line store and the 3x3 window
// ----------------------------------------------------------------------------
`default_nettype none

module gbl_front
    import gbl_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire pix_t                   pixel_in,
    input  wire logic                   frame_start,
    input  wire logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0]    w_last,
    input  wire logic [(MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1)-1:0]  h_last,
    input  wire logic [QCNT_W-1:0]      q_count,
    output logic                        push,
    output window_t                     push_win,
    output item_flags_t                 push_flags,
    output logic [(MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1)-1:0]  push_row,
    output logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0]    push_col
);

    localparam int CW = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;

    logic              accept;
    logic [CW-1:0]     col_count_reg;
    logic [RW-1:0]     row_count_reg;
    logic [CW-1:0]     c_cur;
    logic [RW-1:0]     r_cur;

    logic              s0_valid_reg;
    pix_t              s0_pix_reg;
    logic [CW-1:0]     s0_col_reg;
    logic [RW-1:0]     s0_row_reg;
    item_flags_t       s0_flags_reg;
    logic              s0_byp_reg;
    logic [2*PIX_W-1:0] s0_byp_data_reg;

    logic [2*PIX_W-1:0] ram_rdata;
    logic [2*PIX_W-1:0] line_old;
    logic [2*PIX_W-1:0] line_wdata;

    window_t           win_reg;
    window_t           win_next;

    assign accept = in_valid && !in_stall;
    assign in_stall = ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(s0_valid_reg))
                      >= (QCNT_W+1)'(QUEUE_DEPTH);

    // clamp the stored position into the frame in use; frame_start restarts it at zero
    always_comb
    begin
        if (frame_start)
        begin
            r_cur = '0;
            c_cur = '0;
        end
        else
        begin
            r_cur = (row_count_reg < h_last) ? row_count_reg : h_last;
            c_cur = (col_count_reg < w_last) ? col_count_reg : w_last;
        end
    end

    // upper line in the high byte, lower line in the low byte
    gbl_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s0_valid_reg),
        .waddr (s0_col_reg),
        .wdata (line_wdata),
        .re    (accept),
        .raddr (c_cur),
        .rdata (ram_rdata)
    );

    assign line_old   = s0_byp_reg ? s0_byp_data_reg : ram_rdata;
    assign line_wdata = {line_old[PIX_W-1:0], s0_pix_reg};

    always_comb
    begin
        win_next = win_reg;
        for (int k = 0; k < 3; k++)
        begin
            win_next[k*3]     = win_reg[k*3+1];
            win_next[k*3 + 1] = win_reg[k*3+2];
        end
        win_next[2] = line_old[2*PIX_W-1:PIX_W];
        win_next[5] = line_old[PIX_W-1:0];
        win_next[8] = s0_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s0_valid_reg  <= 1'b0;
            s0_byp_reg    <= 1'b0;
            win_reg       <= '0;
        end
        else
        begin
            s0_valid_reg <= accept;
            if (accept)
            begin
                // same address written by the item ahead in this cycle
                s0_byp_reg <= s0_valid_reg && (c_cur == s0_col_reg);
                if (c_cur == w_last)
                begin
                    col_count_reg <= '0;
                    row_count_reg <= (r_cur == h_last) ? '0 : r_cur + 1'b1;
                end
                else
                begin
                    col_count_reg <= c_cur + 1'b1;
                    row_count_reg <= r_cur;
                end
            end
            if (s0_valid_reg)
            begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_pix_reg            <= pixel_in;
            s0_col_reg            <= c_cur;
            s0_row_reg            <= r_cur;
            s0_byp_data_reg       <= line_wdata;
            s0_flags_reg.has_up   <= (r_cur != '0);
            s0_flags_reg.last_row <= (r_cur == h_last);
            s0_flags_reg.has_left <= (c_cur != '0);
            s0_flags_reg.last_col <= (c_cur == w_last);
        end
    end

    // items that complete no output pixel never enter the queue
    assign push = s0_valid_reg
                  && (s0_flags_reg.has_up || s0_flags_reg.last_row)
                  && (s0_flags_reg.has_left || s0_flags_reg.last_col);
    assign push_win   = win_next;
    assign push_flags = s0_flags_reg;
    assign push_row   = s0_row_reg;
    assign push_col   = s0_col_reg;

endmodule

`default_nettype wire

// ===== rtl/core/gbl_queue.sv =====
// ----------------------------------------------------------------------------
// gbl_queue
// short register queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module gbl_queue
    import gbl_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [WIDTH-1:0]  din,
    input  wire logic              pop,
    output logic      [WIDTH-1:0]  dout,
    output logic      [QCNT_W-1:0] count
);

    localparam int PW = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;

    logic [WIDTH-1:0]  slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = slot_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

`default_nettype wire

// ===== rtl/core/gbl_back.sv =====
// ----------------------------------------------------------------------------
// gbl_back
// walks the output pixels of each queued item and filters them in a pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module gbl_back
    import gbl_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    q_valid,
    input  wire window_t                 q_win,
    input  wire item_flags_t             q_flags,
    input  wire logic [(MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1)-1:0] q_row,
    input  wire logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0]   q_col,
    output logic                         q_pop,
    input  wire coefs_t                  coefs,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output pix_t                         pixel_out,
    output logic [OUT_COORD_W-1:0]       out_row,
    output logic [OUT_COORD_W-1:0]       out_col,
    output logic                         last_of_item,
    output logic                         frame_done
);

    localparam int CW     = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
    localparam int RW     = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;
    localparam int PC_W   = COEF_W + PIX_W;
    localparam int PS_W   = COEF_W + SIDE_SUM_W;
    // three products, two of them full side-sum width
    localparam int ACC_W  = PS_W + 2;

    function automatic pix_t tap(window_t w, logic [1:0] ri, logic [1:0] ci);
        logic [3:0] k;
        k = 4'(ri) * 4'd3 + 4'(ci);
        return w[k];
    endfunction

    logic        en;
    logic        issue;
    logic        active_reg;
    logic        row_own_reg;
    logic        col_own_reg;
    logic        row_own;
    logic        col_own;
    logic        done;
    logic [1:0]  ri [3];
    logic [1:0]  ci [3];

    logic                   a_valid_reg;
    pix_t                   a_center_reg;
    logic [SIDE_SUM_W-1:0]  a_side_reg;
    logic [SIDE_SUM_W-1:0]  a_corner_reg;
    logic [OUT_COORD_W-1:0] a_row_reg;
    logic [OUT_COORD_W-1:0] a_col_reg;
    logic                   a_last_reg;
    logic                   a_fdone_reg;

    logic                   b_valid_reg;
    logic [PC_W-1:0]        b_pc_reg;
    logic [PS_W-1:0]        b_ps_reg;
    logic [PS_W-1:0]        b_pk_reg;
    logic [OUT_COORD_W-1:0] b_row_reg;
    logic [OUT_COORD_W-1:0] b_col_reg;
    logic                   b_last_reg;
    logic                   b_fdone_reg;

    logic [ACC_W-1:0]       acc;
    logic [ACC_W-FRAC_W-1:0] acc_int;

    logic                   out_valid_reg;
    pix_t                   out_pix_reg;
    logic [OUT_COORD_W-1:0] out_row_reg;
    logic [OUT_COORD_W-1:0] out_col_reg;
    logic                   out_last_reg;
    logic                   out_fdone_reg;

    assign en    = !out_valid_reg || !out_stall;
    assign issue = en && q_valid;

    // row/col own: the output sits on the item's own line or column
    assign row_own = active_reg ? row_own_reg : !q_flags.has_up;
    assign col_own = active_reg ? col_own_reg : !q_flags.has_left;
    assign done    = !(!col_own && q_flags.last_col) && !(!row_own && q_flags.last_row);
    assign q_pop   = issue && done;

    // window rows and columns of the three taps, clamped at the frame edges
    always_comb
    begin
        if (row_own)
        begin
            ri[0] = (q_row == '0) ? 2'd2 : 2'd1;
            ri[1] = 2'd2;
            ri[2] = 2'd2;
        end
        else
        begin
            ri[0] = (q_row == RW'(1)) ? 2'd1 : 2'd0;
            ri[1] = 2'd1;
            ri[2] = 2'd2;
        end
        if (col_own)
        begin
            ci[0] = (q_col == '0) ? 2'd2 : 2'd1;
            ci[1] = 2'd2;
            ci[2] = 2'd2;
        end
        else
        begin
            ci[0] = (q_col == CW'(1)) ? 2'd1 : 2'd0;
            ci[1] = 2'd1;
            ci[2] = 2'd2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            row_own_reg   <= 1'b0;
            col_own_reg   <= 1'b0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= issue;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
            if (issue)
            begin
                if (done)
                begin
                    active_reg <= 1'b0;
                end
                else if (!col_own && q_flags.last_col)
                begin
                    active_reg  <= 1'b1;
                    row_own_reg <= row_own;
                    col_own_reg <= 1'b1;
                end
                else
                begin
                    active_reg  <= 1'b1;
                    row_own_reg <= 1'b1;
                    col_own_reg <= !q_flags.has_left;
                end
            end
        end
    end

    assign acc     = ACC_W'(b_pc_reg) + ACC_W'(b_ps_reg) + ACC_W'(b_pk_reg);
    assign acc_int = acc[ACC_W-1:FRAC_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_center_reg <= tap(q_win, ri[1], ci[1]);
            a_side_reg   <= SIDE_SUM_W'(tap(q_win, ri[0], ci[1]))
                          + SIDE_SUM_W'(tap(q_win, ri[2], ci[1]))
                          + SIDE_SUM_W'(tap(q_win, ri[1], ci[0]))
                          + SIDE_SUM_W'(tap(q_win, ri[1], ci[2]));
            a_corner_reg <= SIDE_SUM_W'(tap(q_win, ri[0], ci[0]))
                          + SIDE_SUM_W'(tap(q_win, ri[0], ci[2]))
                          + SIDE_SUM_W'(tap(q_win, ri[2], ci[0]))
                          + SIDE_SUM_W'(tap(q_win, ri[2], ci[2]));
            a_row_reg    <= row_own ? OUT_COORD_W'(q_row) : OUT_COORD_W'(q_row - 1'b1);
            a_col_reg    <= col_own ? OUT_COORD_W'(q_col) : OUT_COORD_W'(q_col - 1'b1);
            a_last_reg   <= done;
            a_fdone_reg  <= row_own && col_own;

            b_pc_reg    <= PC_W'(a_center_reg) * PC_W'(coefs.center);
            b_ps_reg    <= PS_W'(a_side_reg) * PS_W'(coefs.side);
            b_pk_reg    <= PS_W'(a_corner_reg) * PS_W'(coefs.corner);
            b_row_reg   <= a_row_reg;
            b_col_reg   <= a_col_reg;
            b_last_reg  <= a_last_reg;
            b_fdone_reg <= a_fdone_reg;

            out_pix_reg   <= (acc_int > (ACC_W-FRAC_W)'(PIX_MAX)) ? PIX_MAX
                                                               : PIX_W'(acc_int);
            out_row_reg   <= b_row_reg;
            out_col_reg   <= b_col_reg;
            out_last_reg  <= b_last_reg;
            out_fdone_reg <= b_fdone_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_out    = out_pix_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign last_of_item = out_last_reg;
    assign frame_done   = out_fdone_reg;

endmodule

`default_nettype wire

// ===== rtl/core/gaussian_blur_3x3_stream.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_stream
// 3x3 gaussian blur over a raster pixel stream with edge replication
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall carries pixel_in and frame_start; a
//   transfer happens when in_valid is high and in_stall is low
//   output channel: out_valid / out_stall carries pixel_out, out_row,
//   out_col, last_of_item and frame_done, one filtered pixel per transfer
//   config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high, write only while the block is idle
//   throughput: one pixel per cycle while in_stall is low; an item at a row
//   or frame end yields up to four results, one per cycle from the back
//   pipeline while out_stall is low; the four-entry queue absorbs those bursts
//   path: a pixel transfer passes the line ram read and window, the queue
//   slot, then the tap sum, product and sum registers of the back pipeline
//   reset: position, window and queue clear; size and weights take their
//   default values; the line ram holds no reset value
//   a stalled output freezes the whole back pipeline; the front keeps taking
//   pixels until the queue fills, then raises in_stall
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_3x3_stream
    import gbl_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire pix_t                  pixel_in,
    input  wire logic                  frame_start,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output pix_t                       pixel_out,
    output logic [OUT_COORD_W-1:0]     out_row,
    output logic [OUT_COORD_W-1:0]     out_col,
    output logic                       last_of_item,
    output logic                       frame_done,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW  = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
    localparam int RW  = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;
    // wide enough for both the register and the maximum size
    localparam int EWW = (SIZE_W > CW + 1 ? SIZE_W : CW + 1) + 1;
    localparam int EWH = (SIZE_W > RW + 1 ? SIZE_W : RW + 1) + 1;
    localparam int QW  = 9 * PIX_W + 4 + RW + CW;

    logic [SIZE_W-1:0] frame_width_reg;
    logic [SIZE_W-1:0] frame_height_reg;
    coefs_t            coefs_reg;

    logic [EWW-1:0]    w_ext;
    logic [EWH-1:0]    h_ext;
    logic [CW-1:0]     w_last;
    logic [RW-1:0]     h_last;

    logic              q_push;
    logic              q_pop;
    logic [QCNT_W-1:0] q_count;
    window_t           push_win;
    item_flags_t       push_flags;
    logic [RW-1:0]     push_row;
    logic [CW-1:0]     push_col;
    window_t           head_win;
    item_flags_t       head_flags;
    logic [RW-1:0]     head_row;
    logic [CW-1:0]     head_col;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            coefs_reg.center <= RST_COEF_CENTER;
            coefs_reg.side   <= RST_COEF_SIDE;
            coefs_reg.corner <= RST_COEF_CORNER;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[SIZE_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[SIZE_W-1:0];
                REG_COEF_CENTER:  coefs_reg.center <= cfg_data;
                REG_COEF_SIDE:    coefs_reg.side   <= cfg_data;
                REG_COEF_CORNER:  coefs_reg.corner <= cfg_data;
                default:          ;
            endcase
        end
    end

    // last column / row of the frame in use: zero acts as one, large saturates
    assign w_ext  = EWW'(frame_width_reg);
    assign h_ext  = EWH'(frame_height_reg);
    assign w_last = (w_ext == '0) ? '0
                  : (w_ext > EWW'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1)
                  : CW'(w_ext - 1'b1);
    assign h_last = (h_ext == '0) ? '0
                  : (h_ext > EWH'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT - 1)
                  : RW'(h_ext - 1'b1);

    // front: position, line ram and window
    gbl_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_in    (pixel_in),
        .frame_start (frame_start),
        .w_last      (w_last),
        .h_last      (h_last),
        .q_count     (q_count),
        .push        (q_push),
        .push_win    (push_win),
        .push_flags  (push_flags),
        .push_row    (push_row),
        .push_col    (push_col)
    );

    // queue of items that complete at least one output pixel
    gbl_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   ({push_win, push_flags, push_row, push_col}),
        .pop   (q_pop),
        .dout  ({head_win, head_flags, head_row, head_col}),
        .count (q_count)
    );

    // back: result walk, tap sums, weight products, truncate and saturate
    gbl_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_count != '0),
        .q_win        (head_win),
        .q_flags      (head_flags),
        .q_row        (head_row),
        .q_col        (head_col),
        .q_pop        (q_pop),
        .coefs        (coefs_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_out    (pixel_out),
        .out_row      (out_row),
        .out_col      (out_col),
        .last_of_item (last_of_item),
        .frame_done   (frame_done)
    );

    // the frame's final pixel always closes its item
    a_fdone_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> last_of_item)
        else $error("frame_done without last_of_item");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_count != QCNT_W'(QUEUE_DEPTH)) || q_pop)
        else $error("queue overflow");

    // the back never pops an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_count != '0)
        else $error("queue underflow");

endmodule

`default_nettype wire

// ===== verif/tb_gaussian_blur_3x3_stream.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gaussian_blur_3x3_stream
// self-checking bench for the 3x3 gaussian blur pixel stream
// ----------------------------------------------------------------------------
// pixels go in raster order through the input channel; every transfer is fed
// to a software copy of the window and line stores, which queues the filtered
// pixels it must cause; each output transfer is checked field by field
// against the oldest queued pixel; frame size and weights change between
// whole frames, and both channels idle at random
// ----------------------------------------------------------------------------
`default_nettype none

module tb_gaussian_blur_3x3_stream;
    import gbl_pkg::*;

    localparam int MAXW        = DEF_MAX_WIDTH;
    localparam int MAXH        = DEF_MAX_HEIGHT;
    localparam int SETTLE_CYC  = 12;      // pipeline depth plus margin
    localparam int DRAIN_LIMIT = 20000;

    typedef struct {
        logic [PIX_W-1:0]       pix;
        logic [OUT_COORD_W-1:0] row;
        logic [OUT_COORD_W-1:0] col;
        logic                   last;
        logic                   done;
    } blur_pix_t;

    // software copy of the filter plus the queue of filtered pixels owed
    class blur_scoreboard;
        logic [SIZE_W-1:0] width_reg, height_reg;
        logic [COEF_W-1:0] w_center, w_side, w_corner;
        logic [PIX_W-1:0]  upper_line [MAXW];
        logic [PIX_W-1:0]  lower_line [MAXW];
        logic [PIX_W-1:0]  win [9];
        int                next_row, next_col;
        blur_pix_t         owed [$];
        int                errors;

        function new();
            width_reg  = RST_FRAME_WIDTH;
            height_reg = RST_FRAME_HEIGHT;
            w_center   = RST_COEF_CENTER;
            w_side     = RST_COEF_SIDE;
            w_corner   = RST_COEF_CORNER;
            foreach (upper_line[i]) upper_line[i] = '0;
            foreach (lower_line[i]) lower_line[i] = '0;
            foreach (win[i]) win[i] = '0;
            next_row = 0;
            next_col = 0;
            errors   = 0;
        endfunction

        function void note_cfg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_FRAME_WIDTH:  width_reg  = val[SIZE_W-1:0];
                REG_FRAME_HEIGHT: height_reg = val[SIZE_W-1:0];
                REG_COEF_CENTER:  w_center   = val;
                REG_COEF_SIDE:    w_side     = val;
                REG_COEF_CORNER:  w_corner   = val;
                default: ;
            endcase
        endfunction

        function int eff_dim(int v, int lim);
            if (v == 0) return 1;
            return (v > lim) ? lim : v;
        endfunction

        function int clip(int v, int lo, int hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        // window column 2 holds column c, window row 2 holds row r
        function logic [PIX_W-1:0] blur_at(int orow, int ocol, int r, int c, int h, int w);
            longint acc;
            int     rr, cc;
            longint wgt;
            acc = 0;
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    rr = clip(clip(orow + dr, 0, h - 1) - r + 2, 0, 2);
                    cc = clip(clip(ocol + dc, 0, w - 1) - c + 2, 0, 2);
                    if (dr == 0 && dc == 0) wgt = w_center;
                    else if (dr == 0 || dc == 0) wgt = w_side;
                    else wgt = w_corner;
                    acc += wgt * win[rr*3 + cc];
                end
            end
            acc = acc >> FRAC_W;
            return (acc > PIX_MAX) ? PIX_MAX : acc[PIX_W-1:0];
        endfunction

        function void note_pixel(logic [PIX_W-1:0] pix, logic fs);
            int        w, h, r, c, nr, nc, n;
            int        rows [2];
            int        cols [2];
            blur_pix_t e;
            w = eff_dim(width_reg, MAXW);
            h = eff_dim(height_reg, MAXH);
            if (fs) begin
                r = 0;
                c = 0;
            end else begin
                r = (next_row < h - 1) ? next_row : h - 1;
                c = (next_col < w - 1) ? next_col : w - 1;
            end
            for (int k = 0; k < 3; k++) begin
                win[k*3]     = win[k*3 + 1];
                win[k*3 + 1] = win[k*3 + 2];
            end
            win[2] = upper_line[c];
            win[5] = lower_line[c];
            win[8] = pix;
            upper_line[c] = lower_line[c];
            lower_line[c] = pix;

            nr = 0;
            nc = 0;
            if (r >= 1) rows[nr++] = r - 1;
            if (r == h - 1) rows[nr++] = r;
            if (c >= 1) cols[nc++] = c - 1;
            if (c == w - 1) cols[nc++] = c;
            n = 0;
            for (int i = 0; i < nr; i++) begin
                for (int j = 0; j < nc; j++) begin
                    e.pix  = blur_at(rows[i], cols[j], r, c, h, w);
                    e.row  = OUT_COORD_W'(rows[i]);
                    e.col  = OUT_COORD_W'(cols[j]);
                    n++;
                    e.last = (n == nr * nc);
                    e.done = (rows[i] == h - 1) && (cols[j] == w - 1);
                    owed.push_back(e);
                end
            end

            if (c + 1 >= w) begin
                next_col = 0;
                next_row = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                next_col = c + 1;
                next_row = r;
            end
        endfunction

        function void check_result(blur_pix_t got);
            blur_pix_t e;
            if (owed.size() == 0) begin
                $display("%0t: unexpected output pixel %0d at (%0d,%0d)",
                         $realtime, got.pix, got.row, got.col);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (got.pix !== e.pix) begin
                $display("%0t: pixel_out expected %0d actual %0d", $realtime, e.pix, got.pix);
                errors++;
            end
            if (got.row !== e.row) begin
                $display("%0t: out_row expected %0d actual %0d", $realtime, e.row, got.row);
                errors++;
            end
            if (got.col !== e.col) begin
                $display("%0t: out_col expected %0d actual %0d", $realtime, e.col, got.col);
                errors++;
            end
            if (got.last !== e.last) begin
                $display("%0t: last_of_item expected %0d actual %0d",
                         $realtime, e.last, got.last);
                errors++;
            end
            if (got.done !== e.done) begin
                $display("%0t: frame_done expected %0d actual %0d",
                         $realtime, e.done, got.done);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    pix_t                   pixel_in;
    logic                   frame_start;
    logic                   out_valid;
    logic                   out_stall;
    pix_t                   pixel_out;
    logic [OUT_COORD_W-1:0] out_row;
    logic [OUT_COORD_W-1:0] out_col;
    logic                   last_of_item;
    logic                   frame_done;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    blur_scoreboard sb;
    bit             quiet;      // phase with no idling on either side
    int             rand_items;

    gaussian_blur_3x3_stream u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_in     (pixel_in),
        .frame_start  (frame_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_out    (pixel_out),
        .out_row      (out_row),
        .out_col      (out_col),
        .last_of_item (last_of_item),
        .frame_done   (frame_done),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop, far beyond the slowest legal run
    initial
    begin
        #40ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function int idle_cycles();
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    // one pixel transfer; the gap before it is drawn per item
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        int gap;
        gap = idle_cycles();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid    = 1'b1;
        pixel_in    = pix;
        frame_start = fs;
        forever
        begin
            @(posedge clk);
            if (!in_stall) break;
        end
        sb.note_pixel(pix, fs);
    endtask

    // leaves cfg_valid high so back-to-back writes need no drop
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        in_valid  = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        forever
        begin
            @(posedge clk);
            if (cfg_ready) break;
        end
        sb.note_cfg(idx, val);
    endtask

    task automatic setup(input int w, input int h, input int cc, input int cs, input int ck);
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_COEF_CENTER, CFG_DATA_W'(cc));
        write_reg(REG_COEF_SIDE, CFG_DATA_W'(cs));
        write_reg(REG_COEF_CORNER, CFG_DATA_W'(ck));
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // hold the sender until every owed pixel is out, then let the pipe settle
    task automatic drain();
        int n;
        n = 0;
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.owed.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // whole frame of random pixels; a cut frame may stop early (broken frame)
    task automatic send_frame(input int w, input int h, input bit cut);
        int total, stop_at;
        total   = sb.eff_dim(w, MAXW) * sb.eff_dim(h, MAXH);
        stop_at = cut ? $urandom_range(1, total) : total;
        for (int i = 0; i < stop_at; i++)
        begin
            send_pixel(PIX_W'($urandom_range(0, 255)), i == 0);
            rand_items++;
        end
    endtask

    // output side: random stall per result, check on each transfer
    initial
    begin
        int        n;
        blur_pix_t got;
        out_stall = 1'b0;
        forever
        begin
            n = idle_cycles();
            if (n != 0)
            begin
                @(negedge clk);
                out_stall = 1'b1;
                repeat (n) @(posedge clk);
                @(negedge clk);
                out_stall = 1'b0;
            end
            forever
            begin
                @(posedge clk);
                if (out_valid) break;
            end
            got.pix  = pixel_out;
            got.row  = out_row;
            got.col  = out_col;
            got.last = last_of_item;
            got.done = frame_done;
            sb.check_result(got);
        end
    end

    initial
    begin
        int w, h;
        sb          = new();
        quiet       = 1'b0;
        rand_items  = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        pixel_in    = '0;
        frame_start = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_FRAME_WIDTH;
        cfg_data    = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: 3x3 frame with default weights, extreme pixel values
        setup(3, 3, RST_COEF_CENTER, RST_COEF_SIDE, RST_COEF_CORNER);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        // restart mid-frame, then a full frame of max pixels
        send_pixel(8'd170, 1'b1);
        send_pixel(8'd85, 1'b0);
        for (int i = 0; i < 9; i++) send_pixel(8'd255, i == 0);
        drain();

        // single-pixel frames, full-scale weights force saturation
        setup(1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd0, 1'b1);
        drain();

        // zero size acts as one, zero weights give black
        setup(0, 2, 0, 0, 0);
        send_pixel(8'd200, 1'b1);
        send_pixel(8'd77, 1'b0);
        drain();

        // oversized width saturates to the maximum: start of one wide row
        quiet = 1'b1;
        setup(16'h07FF, 1, 16'd30000, 16'd6000, 16'd2000);
        for (int i = 0; i < 16; i++) send_pixel(PIX_W'($urandom_range(0, 255)), i == 0);
        drain();
        // oversized height: top of one tall column
        setup(1, 16'h07FF, 16'd20000, 16'd9000, 16'd2000);
        for (int i = 0; i < 16; i++) send_pixel(PIX_W'($urandom_range(0, 255)), i == 0);
        drain();
        // exact maximum width with two rows, first part of the frame
        setup(MAXW, 2, RST_COEF_CENTER, RST_COEF_SIDE, RST_COEF_CORNER);
        for (int i = 0; i < 16; i++) send_pixel(PIX_W'($urandom_range(0, 255)), i == 0);
        drain();

        // random small frames with random weights
        rand_items = 0;
        while (rand_items < 130)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            case ($urandom_range(0, 3))
                0: setup(w, h, 16'hFFFF, $urandom_range(0, 65535), $urandom_range(0, 65535));
                1: setup(w, h, $urandom_range(0, 65535), 0, 0);
                default: setup(w, h, $urandom_range(0, 40000), $urandom_range(0, 12000),
                               $urandom_range(0, 8000));
            endcase
            repeat ($urandom_range(1, 3)) send_frame(w, h, $urandom_range(0, 7) == 0);
            drain();
        end

        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// ===== gaussian_blur_3x3_stream.f =====
rtl/core/gbl_pkg.sv
rtl/core/gbl_ram.sv
rtl/core/gbl_front.sv
rtl/core/gbl_queue.sv
rtl/core/gbl_back.sv
rtl/core/gaussian_blur_3x3_stream.sv
verif/tb_gaussian_blur_3x3_stream.sv
